// ----- rtl/bal_pkg.sv -----
// ----------------------------------------------------------------------------
// bal_pkg
// shared types and constants for the bounded array list core
// ----------------------------------------------------------------------------
package bal_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned CMD_W        = 2;
    localparam int unsigned POS_W        = 5;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned COUNT_W      = 5;

    localparam logic [DATA_W-1:0] READ_FAIL = {DATA_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SET    = 2'd2,
        CMD_GET    = 2'd3
    } cmd_t;

    // broadcast to every cell along the chain
    typedef struct packed {
        cmd_t              cmd;
        logic              exec;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ----- rtl/bal_cell.sv -----
// ----------------------------------------------------------------------------
// bal_cell
// one list slot: holds an entry and takes from its neighbours on insert/remove
// ----------------------------------------------------------------------------
module bal_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned PW    = 5
) (
    input  logic                          aclk,
    input  bal_pkg::cell_ctrl_t           ctrl,
    input  logic [PW-1:0]                 pos,
    input  logic [PW-1:0]                 count,
    input  logic [bal_pkg::DATA_W-1:0]    left_data,
    input  logic [bal_pkg::DATA_W-1:0]    right_data,
    output logic [bal_pkg::DATA_W-1:0]    data
);

    localparam logic [PW-1:0] MY_IDX  = PW'(INDEX);
    localparam logic [PW-1:0] MY_NEXT = PW'(INDEX + 1);

    logic [bal_pkg::DATA_W-1:0] data_reg;
    logic [bal_pkg::DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.exec) begin
            case (ctrl.cmd)
                bal_pkg::CMD_INSERT: begin
                    if (MY_IDX == pos) begin
                        data_next = ctrl.value;
                    end else if (MY_IDX > pos && MY_IDX <= count) begin
                        data_next = left_data;
                    end
                end
                bal_pkg::CMD_REMOVE: begin
                    if (MY_IDX >= pos && MY_NEXT < count) begin
                        data_next = right_data;
                    end
                end
                bal_pkg::CMD_SET: begin
                    if (MY_IDX == pos) begin
                        data_next = ctrl.value;
                    end
                end
                default: begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- rtl/bounded_array_list_core.sv -----
// ----------------------------------------------------------------------------
// bounded_array_list_core
// fixed-capacity ordered list of 32-bit entries with positional insert/remove
// ----------------------------------------------------------------------------
// The list is a row of CAPACITY cells, one entry each. A command transaction
// is decoded and checked against the entry count in the cycle it is taken;
// every cell then decides locally whether to keep its entry, take its left
// neighbour's (insert), take its right neighbour's (remove) or load the
// command value, so a shift completes at once. Get reads the addressed cell
// through a mux. The result is registered on the m_ side and s_ready stays
// high while that register is empty or being drained, so one command is
// taken every cycle while m_ready is high, and a result appears in the next
// cycle. Rejected commands (full list, position out of range) leave the
// list untouched and return ok low; a rejected get returns -1. Entries hold
// no reset value; only positions below the count can ever be read.
// ----------------------------------------------------------------------------
module bounded_array_list_core #(
    parameter int unsigned CAPACITY = bal_pkg::CAPACITY_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bal_pkg::CMD_W-1:0]           s_command,
    input  logic [bal_pkg::POS_W-1:0]           s_position,
    input  logic signed [bal_pkg::DATA_W-1:0]   s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bal_pkg::DATA_W-1:0]   m_read_value,
    output logic                                m_ok,
    output logic [bal_pkg::COUNT_W-1:0]         m_count
);

    // count width holds CAPACITY itself; compares run at the wider of count/position
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = (CW > bal_pkg::POS_W) ? CW : bal_pkg::POS_W;
    localparam int unsigned IW = $clog2(CAPACITY);
    localparam logic [PW-1:0] CAP_EXT = PW'(CAPACITY);

    logic                          accept;
    bal_pkg::cmd_t                 cmd;
    logic [PW-1:0]                 pos_ext;
    logic [PW-1:0]                 cnt_ext;
    logic                          legal;
    bal_pkg::cell_ctrl_t           ctrl;
    logic [bal_pkg::DATA_W-1:0]    cell_data [CAPACITY];
    logic [bal_pkg::DATA_W-1:0]    rd_data;

    logic [CW-1:0]                 count_reg, count_next;
    logic                          m_valid_reg, m_valid_next;
    logic [bal_pkg::DATA_W-1:0]    rd_reg, rd_next;
    logic                          ok_reg, ok_next;
    logic [bal_pkg::COUNT_W-1:0]   m_count_reg, m_count_next;
    logic [PW-1:0]                 cnt_next_ext;

    // output register frees up when empty or drained this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign cmd     = bal_pkg::cmd_t'(s_command);
    assign pos_ext = PW'(s_position);
    assign cnt_ext = PW'(count_reg);

    // legality check against the current count
    always_comb begin
        case (cmd)
            bal_pkg::CMD_INSERT: legal = (pos_ext <= cnt_ext) && (cnt_ext < CAP_EXT);
            default:             legal = (pos_ext < cnt_ext);
        endcase
    end

    assign ctrl.cmd   = cmd;
    assign ctrl.exec  = accept && legal;
    assign ctrl.value = s_value;

    // chain of cells, neighbour data wired left and right
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [bal_pkg::DATA_W-1:0] left_d;
        logic [bal_pkg::DATA_W-1:0] right_d;

        if (g == 0) begin : g_first
            assign left_d = s_value;
        end else begin : g_mid_l
            assign left_d = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[g];
        end else begin : g_mid_r
            assign right_d = cell_data[g+1];
        end

        bal_cell #(
            .INDEX (g),
            .PW    (PW)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .pos        (pos_ext),
            .count      (cnt_ext),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g])
        );
    end

    // read port for get, only meaningful when the position is below the count
    assign rd_data = cell_data[pos_ext[IW-1:0]];

    always_comb begin
        count_next   = count_reg;
        rd_next      = '0;
        if (ctrl.exec) begin
            case (cmd)
                bal_pkg::CMD_INSERT: count_next = count_reg + CW'(1);
                bal_pkg::CMD_REMOVE: count_next = count_reg - CW'(1);
                default:             count_next = count_reg;
            endcase
        end
        if (cmd == bal_pkg::CMD_GET) begin
            rd_next = legal ? rd_data : bal_pkg::READ_FAIL;
        end
    end

    assign cnt_next_ext = PW'(count_next);
    assign ok_next      = legal;
    assign m_count_next = cnt_next_ext[bal_pkg::COUNT_W-1:0];

    // result register handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, loaded only when a transaction is taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg      <= rd_next;
            ok_reg      <= ok_next;
            m_count_reg <= m_count_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = rd_reg;
    assign m_ok         = ok_reg;
    assign m_count      = m_count_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_ext <= CAP_EXT)
        else $error("entry count beyond capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.exec && cmd == bal_pkg::CMD_INSERT) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_reject_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !legal) |=> (!m_ok && $stable(count_reg)))
        else $error("rejected command changed state or reported ok");

    a_get_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !legal && cmd == bal_pkg::CMD_GET) |=> (rd_reg == bal_pkg::READ_FAIL))
        else $error("rejected get did not return -1");

endmodule

// ----- tb/tb_bounded_array_list_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_array_list_core
// self-checking bench for the bounded array list core: a directed table of
// edge cases then phased random command traffic, each result checked against
// a local list model or hand-typed answer, random idling on both channels
// ----------------------------------------------------------------------------
module tb_bounded_array_list_core;

    localparam int unsigned LIST_CAP        = bal_pkg::CAPACITY_DEF;
    localparam int unsigned NUM_PHASES      = 33;
    localparam int unsigned ITEMS_PER_PHASE = 50;
    localparam int unsigned DRAIN_CYCLES    = 10;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned HOLD_PHASE      = 12;

    // one result transaction as seen on the m_ side
    typedef struct packed {
        logic signed [bal_pkg::DATA_W-1:0] read_value;
        logic                              ok;
        logic [bal_pkg::COUNT_W-1:0]       count;
    } list_result_t;

    // a command handed to the s_ side, with an optional hand-typed answer
    typedef struct packed {
        bal_pkg::cmd_t                     cmd;
        logic [bal_pkg::POS_W-1:0]         pos;
        logic signed [bal_pkg::DATA_W-1:0] value;
        logic                              has_fixed;
        list_result_t                      fixed;
    } command_record_t;

    // directed stimulus row; reps > 1 repeats the command with fresh values
    typedef struct packed {
        bal_pkg::cmd_t                     cmd;
        logic [bal_pkg::POS_W-1:0]         pos;
        logic [bal_pkg::DATA_W-1:0]        value;
        logic [7:0]                        reps;
        logic                              has_fixed;
        list_result_t                      fixed;
    } directed_row_t;

    typedef enum int { MODE_FILL, MODE_MIXED, MODE_DRAIN } phase_mode_t;

    localparam logic [bal_pkg::DATA_W-1:0] VAL_MAX  = 32'h7fff_ffff;
    localparam logic [bal_pkg::DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [bal_pkg::DATA_W-1:0] VAL_ONES = 32'hffff_ffff;
    localparam logic [bal_pkg::DATA_W-1:0] VAL_FAIL = bal_pkg::READ_FAIL;
    localparam list_result_t               NO_FIXED = '0;

    localparam int unsigned NUM_ROWS = 25;
    localparam directed_row_t DIRECTED [NUM_ROWS] = '{
        // empty list: every command is turned away
        '{bal_pkg::CMD_GET,    5'd0,  32'd0,         8'd1,  1'b1, '{VAL_FAIL, 1'b0, 5'd0}},
        '{bal_pkg::CMD_REMOVE, 5'd0,  32'd0,         8'd1,  1'b1, '{32'd0,    1'b0, 5'd0}},
        '{bal_pkg::CMD_SET,    5'd0,  32'd5,         8'd1,  1'b1, '{32'd0,    1'b0, 5'd0}},
        '{bal_pkg::CMD_INSERT, 5'd1,  32'd7,         8'd1,  1'b1, '{32'd0,    1'b0, 5'd0}},
        // build up with the value extremes: list ends as -1, max, min
        '{bal_pkg::CMD_INSERT, 5'd0,  VAL_MAX,       8'd1,  1'b1, '{32'd0,    1'b1, 5'd1}},
        '{bal_pkg::CMD_INSERT, 5'd1,  VAL_MIN,       8'd1,  1'b1, '{32'd0,    1'b1, 5'd2}},
        '{bal_pkg::CMD_INSERT, 5'd0,  VAL_ONES,      8'd1,  1'b1, '{32'd0,    1'b1, 5'd3}},
        // a stored -1 reads back with ok high, unlike a rejected get
        '{bal_pkg::CMD_GET,    5'd0,  32'd0,         8'd1,  1'b1, '{VAL_ONES, 1'b1, 5'd3}},
        '{bal_pkg::CMD_GET,    5'd2,  32'd0,         8'd1,  1'b1, '{VAL_MIN,  1'b1, 5'd3}},
        '{bal_pkg::CMD_GET,    5'd3,  32'd0,         8'd1,  1'b1, '{VAL_FAIL, 1'b0, 5'd3}},
        '{bal_pkg::CMD_SET,    5'd1,  32'd0,         8'd1,  1'b1, '{32'd0,    1'b1, 5'd3}},
        '{bal_pkg::CMD_REMOVE, 5'd0,  32'd0,         8'd1,  1'b1, '{32'd0,    1'b1, 5'd2}},
        '{bal_pkg::CMD_GET,    5'd0,  32'd0,         8'd1,  1'b0, NO_FIXED},
        // top position bit set, far out of range
        '{bal_pkg::CMD_INSERT, 5'd31, 32'd1,         8'd1,  1'b1, '{32'd0,    1'b0, 5'd2}},
        '{bal_pkg::CMD_REMOVE, 5'd31, VAL_ONES,      8'd1,  1'b1, '{32'd0,    1'b0, 5'd2}},
        // fill to capacity through the middle of the list
        '{bal_pkg::CMD_INSERT, 5'd1,  32'd0,         8'd14, 1'b0, NO_FIXED},
        // full list turns inserts away, wherever they point
        '{bal_pkg::CMD_INSERT, 5'd0,  32'd9,         8'd1,  1'b1, '{32'd0,    1'b0, 5'd16}},
        '{bal_pkg::CMD_INSERT, 5'd16, 32'd9,         8'd1,  1'b1, '{32'd0,    1'b0, 5'd16}},
        '{bal_pkg::CMD_GET,    5'd15, 32'd0,         8'd1,  1'b0, NO_FIXED},
        '{bal_pkg::CMD_GET,    5'd16, 32'd0,         8'd1,  1'b1, '{VAL_FAIL, 1'b0, 5'd16}},
        '{bal_pkg::CMD_SET,    5'd15, 32'haaaa_5555, 8'd1,  1'b1, '{32'd0,    1'b1, 5'd16}},
        // remove the last entry, then append at the end again
        '{bal_pkg::CMD_REMOVE, 5'd15, 32'd0,         8'd1,  1'b1, '{32'd0,    1'b1, 5'd15}},
        '{bal_pkg::CMD_INSERT, 5'd15, 32'h5555_5555, 8'd1,  1'b1, '{32'd0,    1'b1, 5'd16}},
        '{bal_pkg::CMD_REMOVE, 5'd0,  32'd0,         8'd1,  1'b1, '{32'd0,    1'b1, 5'd15}},
        '{bal_pkg::CMD_GET,    5'd14, 32'd0,         8'd1,  1'b0, NO_FIXED}
    };

    // clock, reset and dut ports; the driven ones are known from time zero
    logic                              aclk         = 1'b0;
    logic                              aresetn      = 1'b0;
    logic                              s_valid      = 1'b0;
    logic                              s_ready;
    logic [bal_pkg::CMD_W-1:0]         s_command    = '0;
    logic [bal_pkg::POS_W-1:0]         s_position   = '0;
    logic signed [bal_pkg::DATA_W-1:0] s_value      = '0;
    logic                              m_valid;
    logic                              m_ready      = 1'b0;
    logic signed [bal_pkg::DATA_W-1:0] m_read_value;
    logic                              m_ok;
    logic [bal_pkg::COUNT_W-1:0]       m_count;

    // local copy of the list
    logic signed [bal_pkg::DATA_W-1:0] list_entries [LIST_CAP];
    int                                list_len = 0;

    command_record_t issued_q[$];    // driven, not yet taken by the core
    list_result_t    expected_q[$];  // taken, result not yet seen

    int unsigned     error_count = 0;
    int unsigned     cycle_count = 0;
    bit              no_idle     = 1'b0;

    command_record_t taken_cmd;
    list_result_t    predicted;
    list_result_t    wanted;

    bounded_array_list_core #(
        .CAPACITY     (LIST_CAP)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_position   (s_position),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_ok         (m_ok),
        .m_count      (m_count)
    );

    // 2 ns period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run-away guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // apply one command to the local list and return the answer it gives
    function automatic list_result_t apply_list_command(
            input bal_pkg::cmd_t                     cmd,
            input logic [bal_pkg::POS_W-1:0]         pos,
            input logic signed [bal_pkg::DATA_W-1:0] value);
        list_result_t res;
        int           idx;
        int           p;
        res = '0;
        p   = int'(pos);
        case (cmd)
            bal_pkg::CMD_INSERT: begin
                if (p <= list_len && list_len < int'(LIST_CAP)) begin
                    // open a gap at p by moving later entries up
                    for (idx = list_len; idx > p; idx--)
                        list_entries[idx] = list_entries[idx-1];
                    list_entries[p] = value;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            bal_pkg::CMD_REMOVE: begin
                if (p < list_len) begin
                    for (idx = p; idx + 1 < list_len; idx++)
                        list_entries[idx] = list_entries[idx+1];
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            bal_pkg::CMD_SET: begin
                if (p < list_len) begin
                    list_entries[p] = value;
                    res.ok = 1'b1;
                end
            end
            default: begin
                if (p < list_len) begin
                    res.read_value = list_entries[p];
                    res.ok         = 1'b1;
                end else begin
                    res.read_value = bal_pkg::READ_FAIL;
                end
            end
        endcase
        res.count = list_len[bal_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // watch both channels at each edge: predict on s_ side acceptance,
    // check on m_ side acceptance (push first so a same-edge pop is safe)
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (issued_q.size() == 0) begin
                    $display("%0t: s_ side transaction taken with nothing driven", $time);
                    error_count++;
                end else begin
                    taken_cmd = issued_q.pop_front();
                    predicted = apply_list_command(taken_cmd.cmd, taken_cmd.pos,
                                                   taken_cmd.value);
                    // hand-typed rows override, the model still tracks state
                    if (taken_cmd.has_fixed)
                        predicted = taken_cmd.fixed;
                    expected_q.push_back(predicted);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result transaction rd=%0d ok=%0b count=%0d",
                             $time, m_read_value, m_ok, m_count);
                    error_count++;
                end else begin
                    wanted = expected_q.pop_front();
                    if (m_read_value !== wanted.read_value) begin
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, wanted.read_value, m_read_value);
                        error_count++;
                    end
                    if (m_ok !== wanted.ok) begin
                        $display("%0t: ok expected %0b actual %0b",
                                 $time, wanted.ok, m_ok);
                        error_count++;
                    end
                    if (m_count !== wanted.count) begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, wanted.count, m_count);
                        error_count++;
                    end
                end
            end
        end
    end

    // result side: random stall before each transaction, none in quiet phases
    initial begin
        int unsigned stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // drive one command transaction, with a random gap before it, and
    // return at the edge where it is taken
    task automatic drive_list_command(
            input bal_pkg::cmd_t                     cmd,
            input logic [bal_pkg::POS_W-1:0]         pos,
            input logic signed [bal_pkg::DATA_W-1:0] value,
            input logic                              has_fixed,
            input list_result_t                      fixed);
        int unsigned     gap;
        command_record_t rec;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        rec = '{cmd, pos, value, has_fixed, fixed};
        issued_q.push_back(rec);
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_position <= pos;
        s_value    <= value;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    initial begin
        int unsigned                       row;
        int unsigned                       rep;
        int unsigned                       ph;
        int unsigned                       n;
        int unsigned                       roll;
        phase_mode_t                       mode;
        bal_pkg::cmd_t                     cmd;
        logic [bal_pkg::POS_W-1:0]         pos;
        logic signed [bal_pkg::DATA_W-1:0] value;

        // reset held from time zero, released at a rising edge
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (row = 0; row < NUM_ROWS; row++) begin
            for (rep = 0; rep < DIRECTED[row].reps; rep++) begin
                value = (DIRECTED[row].reps > 1) ? $urandom() : DIRECTED[row].value;
                drive_list_command(DIRECTED[row].cmd, DIRECTED[row].pos, value,
                                   DIRECTED[row].has_fixed, DIRECTED[row].fixed);
            end
        end

        // random phases cycling fill, mixed and drain so the list swings
        // between empty and full many times
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            mode    = phase_mode_t'(ph % 3);
            no_idle = (ph % 5 == 3);

            // hold back once until the core has answered everything
            if (ph == HOLD_PHASE) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (issued_q.size() != 0 || expected_q.size() != 0);
            end

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(0, 99);
                case (mode)
                    MODE_FILL:
                        cmd = (roll < 55) ? bal_pkg::CMD_INSERT :
                              (roll < 70) ? bal_pkg::CMD_REMOVE :
                              (roll < 85) ? bal_pkg::CMD_SET : bal_pkg::CMD_GET;
                    MODE_DRAIN:
                        cmd = (roll < 20) ? bal_pkg::CMD_INSERT :
                              (roll < 65) ? bal_pkg::CMD_REMOVE :
                              (roll < 80) ? bal_pkg::CMD_SET : bal_pkg::CMD_GET;
                    default:
                        cmd = bal_pkg::cmd_t'($urandom_range(0, 3));
                endcase

                // mostly in range or right on the count boundary; the model
                // length may lag one transaction, which only skews the mix
                if ($urandom_range(0, 99) < 85)
                    pos = bal_pkg::POS_W'($urandom_range(0, list_len));
                else
                    pos = bal_pkg::POS_W'($urandom_range(0, 31));

                roll = $urandom_range(0, 99);
                case (roll % 4)
                    0: value = (roll < 10) ? VAL_MAX  : $urandom();
                    1: value = (roll < 10) ? VAL_MIN  : $urandom();
                    2: value = (roll < 10) ? VAL_ONES : $urandom();
                    default: value = (roll < 10) ? '0 : $urandom();
                endcase

                drive_list_command(cmd, pos, value, 1'b0, NO_FIXED);
            end
        end

        // let everything drain, then keep waiting for stray results
        s_valid <= 1'b0;
        do @(posedge aclk); while (issued_q.size() != 0 || expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_q.size() != 0) begin
            $display("%0t: %0d result transactions never arrived", $time, expected_q.size());
            error_count++;
        end

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- bounded_array_list_core.f -----
rtl/bal_pkg.sv
rtl/bal_cell.sv
rtl/bounded_array_list_core.sv
tb/tb_bounded_array_list_core.sv
